// ===== rtl/tlb_pkg.sv =====
// Shared types and constants for the TLB lookup/fill block.
// No dependencies; used by every module under rtl/.

package tlb_pkg;

  localparam int TLB_DEPTH_DEF = 8;

  localparam int KEY_W   = 28;
  localparam int FRAME_W = 12;
  localparam int CNT_W   = 32;
  localparam int ACT_W   = 4;

  localparam logic [ACT_W-1:0] ACT_RESET = 4'd4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  segment;
    logic [7:0]  directory;
    logic [11:0] page;
    logic [11:0] fill_frame;
  } tlb_req_t;

  typedef struct packed {
    logic             hit;
    logic [11:0]      frame;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] lookup_count;
  } tlb_rsp_t;

endpackage

// ===== rtl/tlb_match.sv =====
// Parallel key compare across all entries of the TLB.
// Depends on tlb_pkg for the key width.

module tlb_match #(
  parameter int DEPTH = tlb_pkg::TLB_DEPTH_DEF
) (
  input  logic [tlb_pkg::KEY_W-1:0] key,
  input  logic [tlb_pkg::KEY_W-1:0] keys [DEPTH],
  input  logic [DEPTH-1:0]          valid,
  output logic [DEPTH-1:0]          hit_vec
);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec[i] = valid[i] && (keys[i] == key);
    end
  end

endmodule

// ===== rtl/tlb_lru.sv =====
// Valid bits, recency ranks and occupancy of the TLB, plus victim/slot choice.
// Depends on tlb_pkg for the config width.

module tlb_lru #(
  parameter int DEPTH = tlb_pkg::TLB_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      fill,
  input  logic [tlb_pkg::ACT_W-1:0] active,
  input  logic [DEPTH-1:0]          hit_vec,
  output logic [DEPTH-1:0]          valid,
  output logic [DEPTH-1:0]          wr_vec
);

  localparam int RW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCCW = $clog2(DEPTH + 1);
  localparam int LIMW = (OCCW > tlb_pkg::ACT_W) ? OCCW : tlb_pkg::ACT_W;

  logic [DEPTH-1:0] valid_next;
  logic [RW-1:0]    rec [DEPTH];
  logic [RW-1:0]    rec_next [DEPTH];
  logic [OCCW-1:0]  occ, occ_next, occ_m1;
  logic [LIMW-1:0]  limit;
  logic [RW-1:0]    hit_rec;
  logic             found, evict;
  logic [DEPTH-1:0] evict_vec, vmid, free, slot_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rec[i] <= '0;
      end
    end else begin
      valid <= valid_next;
      occ   <= occ_next;
      rec   <= rec_next;
    end
  end

  // Recency ranks of valid entries form a permutation of 0..occ-1, so the
  // LRU entry is the one ranked occ-1.
  always_comb begin
    found   = |hit_vec;
    hit_rec = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) hit_rec = hit_rec | rec[i];
    end

    limit = LIMW'(active);
    if (active == '0) begin
      limit = LIMW'(1);
    end else if (LIMW'(active) > LIMW'(DEPTH)) begin
      limit = LIMW'(DEPTH);
    end

    occ_m1 = occ - OCCW'(1);
    evict  = LIMW'(occ) >= limit;
    for (int i = 0; i < DEPTH; i++) begin
      evict_vec[i] = evict && valid[i] && (rec[i] == occ_m1[RW-1:0]);
    end
    vmid     = valid & ~evict_vec;
    free     = ~vmid;
    slot_vec = free & (~free + DEPTH'(1));  // lowest free entry

    valid_next = valid;
    rec_next   = rec;
    occ_next   = occ;
    wr_vec     = '0;

    if (en) begin
      if (found) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (hit_vec[i]) begin
            rec_next[i] = '0;
          end else if (valid[i] && (rec[i] < hit_rec)) begin
            rec_next[i] = rec[i] + RW'(1);
          end
        end
        if (fill) wr_vec = hit_vec;
      end else if (fill) begin
        valid_next = vmid | slot_vec;
        occ_next   = evict ? occ : occ + OCCW'(1);
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_vec[i]) begin
            rec_next[i] = '0;
          end else if (vmid[i]) begin
            rec_next[i] = rec[i] + RW'(1);
          end
        end
        wr_vec = slot_vec;
      end
    end
  end

  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    occ == OCCW'($countones(valid)))
    else $error("occupancy out of step with valid bits");

  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    en && fill |=> valid != '0)
    else $error("fill left the buffer empty");

  a_lookup_keeps_set: assert property (@(posedge clk) disable iff (rst)
    en && !fill |=> $stable(valid) && $stable(occ))
    else $error("lookup changed the entry set");

endmodule

// ===== rtl/tlb_lru_lookup_fill.sv =====
// Top level of the fully associative TLB with LRU replacement.
// Depends on tlb_pkg, tlb_match and tlb_lru.

// One item per clock: busy is always low, so start may be held high every
// cycle. An item accepted at one edge is registered, compared against all
// entries and applied to the LRU state in the next cycle, and its result is
// on rsp with done high in the cycle after that. The combinational parallel
// key compare and the registered recency update set this rate. The receiver
// cannot stall: each result is present for exactly one cycle.
// Write active_entries (cfg_we/cfg_wdata) only while no item is in flight.

module tlb_lru_lookup_fill #(
  parameter int TLB_DEPTH = tlb_pkg::TLB_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  tlb_pkg::tlb_req_t         req,
  output logic                      done,
  output tlb_pkg::tlb_rsp_t         rsp,
  input  logic                      cfg_we,
  input  logic [tlb_pkg::ACT_W-1:0] cfg_wdata
);

  logic                        in_valid;
  tlb_pkg::tlb_req_t           in_req;
  logic [tlb_pkg::ACT_W-1:0]   active_entries;
  logic [tlb_pkg::KEY_W-1:0]   key;
  logic [tlb_pkg::KEY_W-1:0]   key_mem [TLB_DEPTH];
  logic [tlb_pkg::FRAME_W-1:0] frame_mem [TLB_DEPTH];
  logic [TLB_DEPTH-1:0]        valid, hit_vec, wr_vec;
  logic                        found, is_fill;
  logic [tlb_pkg::FRAME_W-1:0] hit_frame;
  logic [tlb_pkg::CNT_W-1:0]   hits, hits_next, lookups, lookups_next;
  tlb_pkg::tlb_rsp_t           rsp_next;

  assign busy    = 1'b0;
  assign key     = {in_req.segment, in_req.directory, in_req.page};
  assign found   = |hit_vec;
  assign is_fill = in_req.operation == tlb_pkg::OP_FILL;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      done           <= 1'b0;
      hits           <= '0;
      lookups        <= '0;
      active_entries <= tlb_pkg::ACT_RESET;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
      hits     <= hits_next;
      lookups  <= lookups_next;
      if (cfg_we) active_entries <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) in_req <= req;
    if (in_valid) rsp <= rsp_next;
  end

  // Entry storage: key written only for a new key, frame on every fill.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (wr_vec[i]) begin
        frame_mem[i] <= in_req.fill_frame;
        if (!found) key_mem[i] <= key;
      end
    end
  end

  tlb_match #(.DEPTH(TLB_DEPTH)) u_match (
    .key     (key),
    .keys    (key_mem),
    .valid   (valid),
    .hit_vec (hit_vec)
  );

  tlb_lru #(.DEPTH(TLB_DEPTH)) u_lru (
    .clk     (clk),
    .rst     (rst),
    .en      (in_valid),
    .fill    (is_fill),
    .active  (active_entries),
    .hit_vec (hit_vec),
    .valid   (valid),
    .wr_vec  (wr_vec)
  );

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (hit_vec[i]) hit_frame = hit_frame | frame_mem[i];
    end
  end

  always_comb begin
    hits_next    = hits;
    lookups_next = lookups;
    rsp_next     = '0;
    if (in_valid && !is_fill) begin
      if (lookups != '1) lookups_next = lookups + tlb_pkg::CNT_W'(1);
      if (found) begin
        if (hits != '1) hits_next = hits + tlb_pkg::CNT_W'(1);
        rsp_next.hit   = 1'b1;
        rsp_next.frame = hit_frame;
      end
    end
    rsp_next.hit_count    = hits_next;
    rsp_next.lookup_count = lookups_next;
  end

  a_no_dup_key: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> $onehot0(hit_vec))
    else $error("key present in more than one entry");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done == $past(in_valid))
    else $error("result strobe out of step with item");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    done && rsp.hit |-> rsp.hit_count != '0 && rsp.lookup_count != '0)
    else $error("hit reported with zero count");

endmodule

// ===== test/tlb_lru_lookup_fill_chk.sv =====
// Checker for tlb_lru_lookup_fill: tracks the TLB contents and LRU order, predicts
// one response per accepted request and compares each field on every done strobe.
// Depends on tlb_pkg for the request/response structs and the operation codes.

module tlb_lru_lookup_fill_chk #(
  parameter int TLB_DEPTH = tlb_pkg::TLB_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  tlb_pkg::tlb_req_t         req,
  input  logic                      done,
  input  tlb_pkg::tlb_rsp_t         rsp,
  input  logic                      cfg_we,
  input  logic [tlb_pkg::ACT_W-1:0] cfg_wdata,
  output int                        failures,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tlb_pkg::CNT_W-1:0] CNT_SAT = '1;
  localparam logic [2:0]                AGE_MAX = '1;

  // shadow copy of the translation entries
  logic                        ent_valid [TLB_DEPTH];
  logic [tlb_pkg::KEY_W-1:0]   ent_tag   [TLB_DEPTH];
  logic [tlb_pkg::FRAME_W-1:0] ent_pfn   [TLB_DEPTH];
  logic [2:0]                  ent_age   [TLB_DEPTH];   // 0 = most recent
  logic [tlb_pkg::CNT_W-1:0]   hits_seen;
  logic [tlb_pkg::CNT_W-1:0]   lookups_seen;
  logic [tlb_pkg::ACT_W-1:0]   active_cfg;

  tlb_pkg::tlb_rsp_t translation_q[$];
  int                fails = 0;

  assign failures = fails;

  function automatic void clear_entries();
    for (int i = 0; i < TLB_DEPTH; i++) begin
      ent_valid[i] = 1'b0;
      ent_tag[i]   = '0;
      ent_pfn[i]   = '0;
      ent_age[i]   = '0;
    end
    hits_seen    = '0;
    lookups_seen = '0;
    active_cfg   = tlb_pkg::ACT_RESET;
  endfunction

  // hit or refill: only entries younger than this one age
  function automatic void promote(int idx);
    logic [2:0] prev;
    prev = ent_age[idx];
    for (int i = 0; i < TLB_DEPTH; i++)
      if (i != idx && ent_valid[i] && ent_age[i] < prev)
        ent_age[i]++;
    ent_age[idx] = '0;
  endfunction

  // new entry: every other valid entry ages
  function automatic void age_all_but(int idx);
    for (int i = 0; i < TLB_DEPTH; i++)
      if (i != idx && ent_valid[i] && ent_age[i] != AGE_MAX)
        ent_age[i]++;
    ent_age[idx] = '0;
  endfunction

  function automatic int entry_limit();
    if (active_cfg == '0)
      return 1;
    if (int'(active_cfg) > TLB_DEPTH)
      return TLB_DEPTH;
    return int'(active_cfg);
  endfunction

  function automatic tlb_pkg::tlb_rsp_t translate_item(tlb_pkg::tlb_req_t r);
    tlb_pkg::tlb_rsp_t         res;
    logic [tlb_pkg::KEY_W-1:0] key;
    int                        idx;
    int                        used;
    int                        victim;
    int                        slot;
    key    = {r.segment, r.directory, r.page};
    res    = '0;
    idx    = -1;
    used   = 0;
    victim = -1;
    slot   = -1;
    for (int i = 0; i < TLB_DEPTH; i++)
      if (idx < 0 && ent_valid[i] && ent_tag[i] == key)
        idx = i;

    if (r.operation == tlb_pkg::OP_LOOKUP) begin
      if (lookups_seen != CNT_SAT)
        lookups_seen++;
      if (idx >= 0) begin
        if (hits_seen != CNT_SAT)
          hits_seen++;
        res.hit   = 1'b1;
        res.frame = ent_pfn[idx];
        promote(idx);
      end
    end else if (idx >= 0) begin
      ent_pfn[idx] = r.fill_frame;
      promote(idx);
    end else begin
      for (int i = 0; i < TLB_DEPTH; i++)
        if (ent_valid[i])
          used++;
      // at or over the limit: drop one LRU entry, lowest index on a tie
      if (used >= entry_limit()) begin
        for (int i = 0; i < TLB_DEPTH; i++)
          if (ent_valid[i] && (victim < 0 || ent_age[i] > ent_age[victim]))
            victim = i;
        if (victim >= 0)
          ent_valid[victim] = 1'b0;
      end
      for (int i = 0; i < TLB_DEPTH; i++)
        if (slot < 0 && !ent_valid[i])
          slot = i;
      if (slot >= 0) begin
        ent_tag[slot]   = key;
        ent_pfn[slot]   = r.fill_frame;
        ent_valid[slot] = 1'b1;
        age_all_but(slot);
      end
    end
    res.hit_count    = hits_seen;
    res.lookup_count = lookups_seen;
    return res;
  endfunction

  function automatic void check_field(string name, logic [tlb_pkg::CNT_W-1:0] exp_v,
                                      logic [tlb_pkg::CNT_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : watch
    tlb_pkg::tlb_rsp_t exp_rsp;
    if (rst) begin
      clear_entries();
      translation_q.delete();
    end else begin
      if (done) begin
        if (translation_q.size() == 0) begin
          $error("response transfer with no request outstanding");
          fails++;
        end else begin
          exp_rsp = translation_q[0];
          translation_q.delete(0);
          check_field("hit", tlb_pkg::CNT_W'(exp_rsp.hit), tlb_pkg::CNT_W'(rsp.hit));
          check_field("frame", tlb_pkg::CNT_W'(exp_rsp.frame), tlb_pkg::CNT_W'(rsp.frame));
          check_field("hit_count", exp_rsp.hit_count, rsp.hit_count);
          check_field("lookup_count", exp_rsp.lookup_count, rsp.lookup_count);
        end
      end
      if (cfg_we)
        active_cfg = cfg_wdata;
      if (start && !busy)
        translation_q.insert(translation_q.size(), translate_item(req));
    end
    pending <= translation_q.size();
  end

endmodule

// ===== test/tlb_lru_lookup_fill_tb.sv =====
// Testbench top for tlb_lru_lookup_fill: clock, reset, request stimulus and
// active_entries writes between phases; checking is done in tlb_lru_lookup_fill_chk.
// Depends on tlb_pkg, the RTL under rtl/ and test/tlb_lru_lookup_fill_chk.sv.

module tlb_lru_lookup_fill_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 160;
  localparam int SETTLE      = 4;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  tlb_pkg::tlb_req_t         req = '0;
  logic                      done;
  tlb_pkg::tlb_rsp_t         rsp;
  logic                      cfg_we = 1'b0;
  logic [tlb_pkg::ACT_W-1:0] cfg_wdata = '0;
  int                        failures;
  int                        pending;
  int                        cycles = 0;

  // includes out-of-range settings: 0 acts as 1, above the depth saturates
  logic [tlb_pkg::ACT_W-1:0] settings [10] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd7,
                                               4'd3, 4'd9, 4'd6, 4'd5};

  always #10 clk = ~clk;

  tlb_lru_lookup_fill u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tlb_lru_lookup_fill_chk u_chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic tlb_pkg::tlb_req_t mk_req(logic op, logic [7:0] seg, logic [7:0] dir,
                                               logic [11:0] pg, logic [11:0] frm);
    tlb_pkg::tlb_req_t r;
    r.operation  = op;
    r.segment    = seg;
    r.directory  = dir;
    r.page       = pg;
    r.fill_frame = frm;
    return r;
  endfunction

  // biased toward the field extremes
  function automatic logic [11:0] pick_val(logic [11:0] maxv);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return maxv;
      default: return 12'($urandom) & maxv;
    endcase
  endfunction

  function automatic tlb_pkg::tlb_req_t rand_req();
    return mk_req(1'($urandom), 8'(pick_val(12'hFF)), 8'(pick_val(12'hFF)),
                  pick_val(12'hFFF), pick_val(12'hFFF));
  endfunction

  task automatic send(tlb_pkg::tlb_req_t item, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every outstanding response has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_active(logic [tlb_pkg::ACT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(int n_items);
    tlb_pkg::tlb_req_t pool [12];
    tlb_pkg::tlb_req_t item;
    int                pool_n;
    int                roll;
    bit                burst;
    pool_n = $urandom_range(2, 12);
    burst  = 1'b0;
    for (int i = 0; i < pool_n; i++)
      pool[i] = rand_req();
    for (int i = 0; i < n_items; i++) begin
      if (i % 32 == 0)
        burst = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        // reuse a working-set key so lookups hit and fills hit the LRU logic
        item            = pool[$urandom_range(0, pool_n - 1)];
        item.operation  = 1'($urandom);
        item.fill_frame = pick_val(12'hFFF);
      end else if (roll < 90) begin
        item = rand_req();
      end else begin
        // one key bit off from a cached key
        item = pool[$urandom_range(0, pool_n - 1)];
        item.operation = 1'($urandom);
        {item.segment, item.directory, item.page} =
          {item.segment, item.directory, item.page} ^ (28'd1 << $urandom_range(0, 27));
      end
      send(item, burst ? 0 : $urandom_range(0, 9));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part, active_entries at its reset value of 4
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h00, 8'h00, 12'h000, 12'h5A5), 0);  // miss on empty TLB
    send(mk_req(tlb_pkg::OP_FILL, 8'h00, 8'h00, 12'h000, 12'hFFF), 1);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h00, 8'h00, 12'h000, 12'h000), 0);
    send(mk_req(tlb_pkg::OP_FILL, 8'hFF, 8'hFF, 12'hFFF, 12'h000), 2);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF), 0);
    send(mk_req(tlb_pkg::OP_FILL, 8'hFF, 8'hFF, 12'hFFF, 12'hABC), 0);  // refill of cached key
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'hFF, 8'hFF, 12'hFFF, 12'h000), 3);
    send(mk_req(tlb_pkg::OP_FILL, 8'h12, 8'h34, 12'h567, 12'h001), 0);
    send(mk_req(tlb_pkg::OP_FILL, 8'h80, 8'h01, 12'h800, 12'h800), 0);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h00, 8'h00, 12'h000, 12'h000), 0);
    send(mk_req(tlb_pkg::OP_FILL, 8'h55, 8'hAA, 12'h555, 12'h7FF), 0);  // evicts all-ones key
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'hFF, 8'hFF, 12'hFFF, 12'h000), 0);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h00, 8'h00, 12'h000, 12'h000), 1);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h12, 8'h34, 12'h567, 12'h000), 0);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h80, 8'h01, 12'h800, 12'h000), 0);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h55, 8'hAA, 12'h555, 12'h000), 0);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h55, 8'hAA, 12'h554, 12'h000), 0);  // near miss
    send(mk_req(tlb_pkg::OP_FILL, 8'hAA, 8'h55, 12'hAAA, 12'h123), 2);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h12, 8'h34, 12'h567, 12'h000), 0);
    send(mk_req(tlb_pkg::OP_FILL, 8'h01, 8'h80, 12'h001, 12'hFFE), 0);
    send(mk_req(tlb_pkg::OP_LOOKUP, 8'h80, 8'h01, 12'h800, 12'h000), 0);
    drain();

    foreach (settings[s]) begin
      write_active(settings[s]);
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (failures == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
